FILE: hdl/nqpt_pkg.sv
// Shared types, codes and constants of the NVMe queue pair tracker.
`timescale 1ns / 1ps
`default_nettype none

package nqpt_pkg;

    // Queue depth default and fixed field widths.
    localparam int unsigned QUEUE_DEPTH_DEF = 1024;
    localparam int unsigned SLOT_W          = 10;
    localparam int unsigned TIMEOUT_W       = 23;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = TIMEOUT_W;
    localparam int unsigned JOBQ_DEPTH      = 2;

    localparam logic [TIMEOUT_W-1:0] IO_TIMEOUT_RST    = TIMEOUT_W'(5000000);
    localparam logic [TIMEOUT_W-1:0] FLUSH_TIMEOUT_RST = TIMEOUT_W'(1000000);
    localparam logic [15:0]          FIRST_CMD_ID      = 16'h0001;
    localparam logic [31:0]          FLUSH_NAMESPACE   = 32'h0000_0001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IO_TIMEOUT    = 1'b0,
        CFG_FLUSH_TIMEOUT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_POLL  = 2'd3
    } mode_t;

    typedef enum logic [7:0] {
        OPC_FLUSH = 8'h00,
        OPC_WRITE = 8'h01,
        OPC_READ  = 8'h02
    } opcode_t;

    typedef enum logic [2:0] {
        OC_SUBMITTED = 3'd0,
        OC_COMPLETED = 3'd1,
        OC_NOT_YET   = 3'd2,
        OC_TIMEOUT   = 3'd3,
        OC_REFUSED   = 3'd4
    } outcome_t;

    // One classified request, as it travels from front to back.
    typedef struct packed {
        logic        is_poll;
        logic        is_flush;
        opcode_t     opcode;
        logic [31:0] nsid;
        logic [63:0] prp1;
        logic [31:0] dw10;
        logic [31:0] dw11;
        logic [31:0] dw12;
        logic        phase;
        logic [14:0] status;
        logic [15:0] cqe_cid;
    } nqpt_job_t;

    // One result, as held in the output register.
    typedef struct packed {
        outcome_t    outcome;
        logic [SLOT_W-1:0] slot_index;
        logic [31:0] entry_dword0;
        logic [31:0] entry_namespace;
        logic [63:0] entry_prp1;
        logic [31:0] entry_dword10;
        logic [31:0] entry_dword11;
        logic [31:0] entry_dword12;
        logic [SLOT_W-1:0] doorbell_value;
        logic [14:0] completion_status;
        logic [15:0] command_id;
    } nqpt_res_t;

endpackage

`default_nettype wire

FILE: hdl/nqpt_if.sv
// Request and result channel interfaces of the NVMe queue pair tracker.
`timescale 1ns / 1ps
`default_nettype none

interface nqpt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] namespace_id;
    logic [63:0] start_block;
    logic [15:0] lba_count;
    logic [63:0] buffer_address;
    logic [15:0] cqe_status_word;
    logic [15:0] cqe_command_id;

    modport source (
        output valid, mode, namespace_id, start_block, lba_count,
               buffer_address, cqe_status_word, cqe_command_id,
        input  ready
    );
    modport sink (
        input  valid, mode, namespace_id, start_block, lba_count,
               buffer_address, cqe_status_word, cqe_command_id,
        output ready
    );
endinterface

interface nqpt_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic [9:0]  slot_index;
    logic [31:0] entry_dword0;
    logic [31:0] entry_namespace;
    logic [63:0] entry_prp1;
    logic [31:0] entry_dword10;
    logic [31:0] entry_dword11;
    logic [31:0] entry_dword12;
    logic [9:0]  doorbell_value;
    logic [14:0] completion_status;
    logic [15:0] command_id;

    modport source (
        output valid, outcome, slot_index, entry_dword0, entry_namespace, entry_prp1,
               entry_dword10, entry_dword11, entry_dword12, doorbell_value,
               completion_status, command_id,
        input  ready
    );
    modport sink (
        input  valid, outcome, slot_index, entry_dword0, entry_namespace, entry_prp1,
               entry_dword10, entry_dword11, entry_dword12, doorbell_value,
               completion_status, command_id,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/nqpt_front.sv
// Front end: accepts requests and packs them into classified jobs.
`timescale 1ns / 1ps
`default_nettype none

module nqpt_front
    import nqpt_pkg::*;
(
    nqpt_cmd_if.sink        cmd,
    input  wire logic       q_full,
    output logic            q_push,
    output nqpt_job_t       q_job
);

    assign cmd.ready = ~q_full;
    assign q_push    = cmd.valid & ~q_full;

    always_comb
    begin
        q_job          = '0;
        q_job.phase    = cmd.cqe_status_word[0];
        q_job.status   = cmd.cqe_status_word[15:1];
        q_job.cqe_cid  = cmd.cqe_command_id;
        unique case (mode_t'(cmd.mode))
            MODE_READ, MODE_WRITE:
            begin
                q_job.opcode = (mode_t'(cmd.mode) == MODE_READ) ? OPC_READ : OPC_WRITE;
                q_job.nsid   = cmd.namespace_id;
                q_job.prp1   = cmd.buffer_address;
                q_job.dw10   = cmd.start_block[31:0];
                q_job.dw11   = cmd.start_block[63:32];
                // A zero count wraps to all ones.
                q_job.dw12   = {16'h0000, cmd.lba_count} - 32'd1;
            end
            MODE_FLUSH:
            begin
                q_job.opcode   = OPC_FLUSH;
                q_job.is_flush = 1'b1;
                q_job.nsid     = FLUSH_NAMESPACE;
            end
            MODE_POLL:
            begin
                q_job.is_poll = 1'b1;
            end
            default:
            begin
                q_job.is_poll = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/nqpt_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module nqpt_queue
    import nqpt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire nqpt_job_t push_job,
    input  wire logic      pop,
    output logic           full,
    output logic           empty,
    output nqpt_job_t      head_job
);

    localparam int unsigned AW = $clog2(JOBQ_DEPTH);
    localparam int unsigned CW = $clog2(JOBQ_DEPTH + 1);

    nqpt_job_t         slot_reg [JOBQ_DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg,  count_next;

    assign full     = (count_reg == CW'(JOBQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/nqpt_back.sv
// Back end: queue pair state, timeout registers and the result register.
`timescale 1ns / 1ps
`default_nettype none

module nqpt_back
    import nqpt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  q_empty,
    input  wire nqpt_job_t             q_job,
    output logic                       q_pop,
    nqpt_res_if.source                 res
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned EXT_W = PTR_W + SLOT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [TIMEOUT_W-1:0] io_timeout_reg, flush_timeout_reg;
    logic [PTR_W-1:0]     tail_reg,  tail_next;
    logic [PTR_W-1:0]     head_reg,  head_next;
    logic                 phase_reg, phase_next;
    logic [15:0]          next_id_reg, next_id_next;
    logic                 pend_reg,  pend_next;
    logic [15:0]          pend_id_reg, pend_id_next;
    logic                 pend_flush_reg, pend_flush_next;
    logic [TIMEOUT_W-1:0] miss_reg,  miss_next;
    logic                 res_valid_reg, res_valid_next;
    nqpt_res_t            res_reg,   res_next;

    logic [PTR_W-1:0]     tail_inc, head_inc;
    logic [EXT_W-1:0]     tail_ext, tail_inc_ext, head_ext, head_inc_ext;
    logic [TIMEOUT_W-1:0] limit, miss_inc;

    assign q_pop = ~q_empty & (~res_valid_reg | res.ready);

    assign tail_inc     = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    assign head_inc     = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign tail_ext     = {{SLOT_W{1'b0}}, tail_reg};
    assign tail_inc_ext = {{SLOT_W{1'b0}}, tail_inc};
    assign head_ext     = {{SLOT_W{1'b0}}, head_reg};
    assign head_inc_ext = {{SLOT_W{1'b0}}, head_inc};
    assign miss_inc     = miss_reg + 1'b1;

    always_comb
    begin
        limit = pend_flush_reg ? flush_timeout_reg : io_timeout_reg;
        if (limit == '0)
        begin
            limit = TIMEOUT_W'(1);
        end
    end

    always_comb
    begin
        tail_next       = tail_reg;
        head_next       = head_reg;
        phase_next      = phase_reg;
        next_id_next    = next_id_reg;
        pend_next       = pend_reg;
        pend_id_next    = pend_id_reg;
        pend_flush_next = pend_flush_reg;
        miss_next       = miss_reg;
        res_valid_next  = res_valid_reg & ~res.ready;
        res_next        = res_reg;
        if (q_pop)
        begin
            res_valid_next = 1'b1;
            res_next       = '0;
            priority if ((!q_job.is_poll && pend_reg) || (q_job.is_poll && !pend_reg))
            begin
                res_next.outcome = OC_REFUSED;
            end
            else if (!q_job.is_poll)
            begin
                res_next.outcome         = OC_SUBMITTED;
                res_next.slot_index      = tail_ext[SLOT_W-1:0];
                res_next.entry_dword0    = {next_id_reg, 8'h00, q_job.opcode};
                res_next.entry_namespace = q_job.nsid;
                res_next.entry_prp1      = q_job.prp1;
                res_next.entry_dword10   = q_job.dw10;
                res_next.entry_dword11   = q_job.dw11;
                res_next.entry_dword12   = q_job.dw12;
                res_next.doorbell_value  = tail_inc_ext[SLOT_W-1:0];
                res_next.command_id      = next_id_reg;
                tail_next                = tail_inc;
                next_id_next             = next_id_reg + 1'b1;
                pend_next                = 1'b1;
                pend_id_next             = next_id_reg;
                pend_flush_next          = q_job.is_flush;
                miss_next                = '0;
            end
            else if (q_job.phase == phase_reg && q_job.cqe_cid == pend_id_reg)
            begin
                res_next.outcome           = OC_COMPLETED;
                res_next.slot_index        = head_ext[SLOT_W-1:0];
                res_next.doorbell_value    = head_inc_ext[SLOT_W-1:0];
                res_next.completion_status = q_job.status;
                res_next.command_id        = pend_id_reg;
                head_next                  = head_inc;
                if (head_inc == '0)
                begin
                    phase_next = ~phase_reg;
                end
                pend_next = 1'b0;
                miss_next = '0;
            end
            else
            begin
                res_next.slot_index = head_ext[SLOT_W-1:0];
                res_next.command_id = pend_id_reg;
                if (miss_inc >= limit)
                begin
                    res_next.outcome = OC_TIMEOUT;
                    pend_next        = 1'b0;
                    miss_next        = '0;
                end
                else
                begin
                    res_next.outcome = OC_NOT_YET;
                    miss_next        = miss_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_timeout_reg    <= IO_TIMEOUT_RST;
            flush_timeout_reg <= FLUSH_TIMEOUT_RST;
            tail_reg          <= '0;
            head_reg          <= '0;
            phase_reg         <= 1'b1;
            next_id_reg       <= FIRST_CMD_ID;
            pend_reg          <= 1'b0;
            pend_id_reg       <= '0;
            pend_flush_reg    <= 1'b0;
            miss_reg          <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_IO_TIMEOUT:    io_timeout_reg    <= cfg_data;
                    CFG_FLUSH_TIMEOUT: flush_timeout_reg <= cfg_data;
                    default:           io_timeout_reg    <= io_timeout_reg;
                endcase
            end
            tail_reg       <= tail_next;
            head_reg       <= head_next;
            phase_reg      <= phase_next;
            next_id_reg    <= next_id_next;
            pend_reg       <= pend_next;
            pend_id_reg    <= pend_id_next;
            pend_flush_reg <= pend_flush_next;
            miss_reg       <= miss_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res.valid             = res_valid_reg;
    assign res.outcome           = res_reg.outcome;
    assign res.slot_index        = res_reg.slot_index;
    assign res.entry_dword0      = res_reg.entry_dword0;
    assign res.entry_namespace   = res_reg.entry_namespace;
    assign res.entry_prp1        = res_reg.entry_prp1;
    assign res.entry_dword10     = res_reg.entry_dword10;
    assign res.entry_dword11     = res_reg.entry_dword11;
    assign res.entry_dword12     = res_reg.entry_dword12;
    assign res.doorbell_value    = res_reg.doorbell_value;
    assign res.completion_status = res_reg.completion_status;
    assign res.command_id        = res_reg.command_id;

endmodule

`default_nettype wire

FILE: hdl/nvme_queue_pair_tracker_top.sv
// Top level of the NVMe queue pair tracker: front end, job queue and back end.
//
// The block tracks the host side of one NVMe I/O queue pair with a single
// command in flight. Each request on the cmd channel is a read, write or
// flush submission, or a poll that presents the completion entry at the head.
// Every request yields exactly one result on the res channel: the packed
// submission entry with its slot and tail doorbell value, the completion
// status with the new head doorbell value, a not-yet or timeout notice, or a
// refusal when a submission arrives while a command is pending or a poll
// arrives while none is.
// The accepting edge writes the request into the job queue, and a later
// edge pops it, updates the queue pair state and loads the output register.
// The back end takes one request per cycle while its output register is
// free or being read, which sets the sustained rate.
// When the receiver stalls, the result stays in the output register and the
// two-entry job queue absorbs further requests; cmd.ready drops once it fills.
// The user must write the timeout registers through cfg_we, cfg_index and
// cfg_data while the block is idle; the block does not enforce this. Reset
// clears the pointers, sets the expected phase and the next command id to
// one, drops any pending command and reloads the default timeouts.
`timescale 1ns / 1ps
`default_nettype none

module nvme_queue_pair_tracker_top
    import nqpt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    nqpt_cmd_if.sink                   cmd,
    nqpt_res_if.source                 res
);

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    nqpt_job_t push_job;
    nqpt_job_t head_job;

    // Front end: decodes the mode and packs the submission fields.
    nqpt_front u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    // Job queue lets the front end keep accepting while results stall.
    nqpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_job (head_job)
    );

    // Back end: owns all queue pair state and the result register.
    nqpt_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .res       (res)
    );

endmodule

`default_nettype wire

FILE: hdl/nqpt_checker.sv
// Port-level checks of the NVMe queue pair tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nqpt_checker
    import nqpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        res_valid,
    input  wire logic        res_ready,
    input  wire logic [2:0]  outcome,
    input  wire logic [9:0]  slot_index,
    input  wire logic [31:0] entry_dword0,
    input  wire logic [63:0] entry_prp1,
    input  wire logic [9:0]  doorbell_value,
    input  wire logic [14:0] completion_status,
    input  wire logic [15:0] command_id
);

    // A submitted entry carries its command id in the top half of dword 0.
    a_submit_id: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && outcome == OC_SUBMITTED) |-> entry_dword0[31:16] == command_id)
        else $error("submitted entry id mismatch");

    // A submission never reports completion status.
    a_submit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && outcome == OC_SUBMITTED) |-> completion_status == 15'd0)
        else $error("submission with nonzero status");

    // Completions carry no submission entry.
    a_complete_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && outcome == OC_COMPLETED) |-> (entry_dword0 == 32'd0 && entry_prp1 == 64'd0))
        else $error("completion with entry fields");

    // A refusal clears every other field.
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && outcome == OC_REFUSED)
            |-> (slot_index == 10'd0 && command_id == 16'd0 && doorbell_value == 10'd0))
        else $error("refusal with nonzero fields");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(outcome) && $stable(command_id)))
        else $error("stalled result changed");

endmodule

bind nvme_queue_pair_tracker_top nqpt_checker u_nqpt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .outcome           (res.outcome),
    .slot_index        (res.slot_index),
    .entry_dword0      (res.entry_dword0),
    .entry_prp1        (res.entry_prp1),
    .doorbell_value    (res.doorbell_value),
    .completion_status (res.completion_status),
    .command_id        (res.command_id)
);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the NVMe queue pair tracker with its own queue pair predictor.
`timescale 1ns / 1ps

// The testbench drives requests into the cmd channel and keeps a copy of the
// queue pair state. It predicts the one result that each accepted request
// produces and checks the res channel against those predictions in order.
// Stimulus runs in named tests, one after the other:
//   - hand-picked submissions and polls: field extremes, refusals, the
//     flush layout and the zero block count,
//   - short timeouts for both kinds of command and the maximum for a flush,
//   - a long result stall that fills the block and stalls its input,
//   - random traffic under several timeout settings. Most of it is built
//     from the predicted state, so that commands really complete or time out.
module tb;
    import nqpt_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int QDEPTH     = QUEUE_DEPTH_DEF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = '1;

    // One request as the host would hand it to the block.
    typedef struct {
        mode_t       mode;
        logic [31:0] nsid;
        logic [63:0] slba;
        logic [15:0] nlb;
        logic [63:0] prp;
        logic [15:0] sw;
        logic [15:0] ccid;
    } host_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nqpt_cmd_if cmd_ch();
    nqpt_res_if res_ch();

    nvme_queue_pair_tracker_top #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Predicted queue pair state. The initial values are the state after reset.
    logic [SLOT_W-1:0]    sq_tail       = '0;
    logic [SLOT_W-1:0]    cq_head       = '0;
    logic                 exp_phase     = 1'b1;
    logic [15:0]          next_cid      = FIRST_CMD_ID;
    logic                 cmd_pending   = 1'b0;
    logic [15:0]          pending_cid   = '0;
    logic                 pending_flush = 1'b0;
    logic [TIMEOUT_W-1:0] misses        = '0;
    logic [TIMEOUT_W-1:0] io_limit      = IO_TIMEOUT_RST;
    logic [TIMEOUT_W-1:0] flush_limit   = FLUSH_TIMEOUT_RST;

    // Results predicted for accepted requests, oldest first.
    nqpt_res_t predicted_results[$];

    int failures          = 0;
    int requests_sent     = 0;
    int outcome_count[5]  = '{default: 0};

    // Random idling on both channels is allowed while this is set.
    bit idle_enable       = 1'b0;
    // A test sets this to hold the result side stalled; the driver counts it down.
    int sink_hold_request = 0;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard limit on the run.
    initial begin
        #(CLK_PERIOD * 1000000);
        $display("Verification failed");
        $finish;
    end

    // Works out the result of one accepted request and updates the predicted state.
    function automatic nqpt_res_t predict_queue_pair_step(host_req_t r);
        nqpt_res_t            e;
        opcode_t              opc;
        logic [TIMEOUT_W-1:0] limit;
        e = '0;
        e.outcome = OC_REFUSED;
        if (r.mode != MODE_POLL) begin
            // A second submission while one is in flight is turned away.
            if (cmd_pending)
                return e;
            case (r.mode)
                MODE_READ:  opc = OPC_READ;
                MODE_WRITE: opc = OPC_WRITE;
                default:    opc = OPC_FLUSH;
            endcase
            e.outcome      = OC_SUBMITTED;
            e.slot_index   = sq_tail;
            e.entry_dword0 = {next_cid, 8'h00, opc};
            if (r.mode == MODE_FLUSH) begin
                e.entry_namespace = FLUSH_NAMESPACE;
            end
            else begin
                e.entry_namespace = r.nsid;
                e.entry_prp1      = r.prp;
                e.entry_dword10   = r.slba[31:0];
                e.entry_dword11   = r.slba[63:32];
                // A zero block count wraps to all ones.
                e.entry_dword12   = {16'h0000, r.nlb} - 32'd1;
            end
            e.command_id     = next_cid;
            sq_tail          = SLOT_W'((int'(sq_tail) + 1) % QDEPTH);
            e.doorbell_value = sq_tail;
            pending_cid      = next_cid;
            next_cid         = next_cid + 16'd1;
            cmd_pending      = 1'b1;
            pending_flush    = (r.mode == MODE_FLUSH);
            misses           = '0;
        end
        else if (cmd_pending) begin
            e.slot_index = cq_head;
            e.command_id = pending_cid;
            if (r.sw[0] == exp_phase && r.ccid == pending_cid) begin
                e.outcome = OC_COMPLETED;
                cq_head   = SLOT_W'((int'(cq_head) + 1) % QDEPTH);
                if (cq_head == '0)
                    exp_phase = ~exp_phase;
                e.doorbell_value    = cq_head;
                e.completion_status = r.sw[15:1];
                cmd_pending         = 1'b0;
                misses              = '0;
            end
            else begin
                // A timeout register of zero behaves as one.
                limit = pending_flush ? flush_limit : io_limit;
                if (limit == '0)
                    limit = TIMEOUT_W'(1);
                misses = misses + 1'b1;
                if (misses >= limit) begin
                    e.outcome   = OC_TIMEOUT;
                    cmd_pending = 1'b0;
                    misses      = '0;
                end
                else begin
                    e.outcome = OC_NOT_YET;
                end
            end
        end
        return e;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // Result side: every accepted result is matched against the oldest prediction.
    always @(posedge clk) begin : result_checker
        nqpt_res_t exp_res;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (predicted_results.size() == 0) begin
                $error("result arrived with no request waiting for one");
                failures++;
            end
            else begin
                exp_res = predicted_results.pop_front();
                outcome_count[exp_res.outcome]++;
                check_field("outcome",           exp_res.outcome,           res_ch.outcome);
                check_field("slot_index",        exp_res.slot_index,        res_ch.slot_index);
                check_field("entry_dword0",      exp_res.entry_dword0,      res_ch.entry_dword0);
                check_field("entry_namespace",   exp_res.entry_namespace,   res_ch.entry_namespace);
                check_field("entry_prp1",        exp_res.entry_prp1,        res_ch.entry_prp1);
                check_field("entry_dword10",     exp_res.entry_dword10,     res_ch.entry_dword10);
                check_field("entry_dword11",     exp_res.entry_dword11,     res_ch.entry_dword11);
                check_field("entry_dword12",     exp_res.entry_dword12,     res_ch.entry_dword12);
                check_field("doorbell_value",    exp_res.doorbell_value,    res_ch.doorbell_value);
                check_field("completion_status", exp_res.completion_status,
                            res_ch.completion_status);
                check_field("command_id",        exp_res.command_id,        res_ch.command_id);
            end
        end
    end

    // Result ready. Random stalls come in short bursts; a requested hold
    // stalls the result side for a long stretch, counted here.
    initial begin : result_ready_driver
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold_request > 0) begin
                stall_left        = sink_hold_request;
                sink_hold_request = 0;
            end
            else if (stall_left == 0 && idle_enable && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one request from a falling edge and returns at the falling edge
    // after it was accepted. Valid stays high, so back-to-back requests flow
    // without a gap unless a random idle burst is drawn.
    task automatic send_request(host_req_t r);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        cmd_ch.valid           <= 1'b1;
        cmd_ch.mode            <= r.mode;
        cmd_ch.namespace_id    <= r.nsid;
        cmd_ch.start_block     <= r.slba;
        cmd_ch.lba_count       <= r.nlb;
        cmd_ch.buffer_address  <= r.prp;
        cmd_ch.cqe_status_word <= r.sw;
        cmd_ch.cqe_command_id  <= r.ccid;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        predicted_results.push_back(predict_queue_pair_step(r));
        requests_sent++;
        @(negedge clk);
    endtask

    // Stops offering and waits until every predicted result has been seen.
    task automatic drain_results(int max_cycles);
        int waited;
        waited = 0;
        cmd_ch.valid <= 1'b0;
        while (predicted_results.size() != 0 && waited < max_cycles) begin
            @(posedge clk);
            waited++;
        end
        @(negedge clk);
    endtask

    // Writes both timeout registers on back-to-back edges; the block must be idle.
    task automatic set_timeouts(logic [CFG_DATA_W-1:0] io_value,
                                logic [CFG_DATA_W-1:0] flush_value);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IO_TIMEOUT;
        cfg_data  <= io_value;
        @(negedge clk);
        cfg_index <= CFG_FLUSH_TIMEOUT;
        cfg_data  <= flush_value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        io_limit    = io_value;
        flush_limit = flush_value;
    endtask

    function automatic host_req_t random_request(mode_t m);
        host_req_t r;
        r.mode = m;
        r.nsid = $urandom;
        r.slba = {$urandom, $urandom};
        r.nlb  = $urandom;
        r.prp  = {$urandom, $urandom};
        r.sw   = $urandom;
        r.ccid = $urandom;
        return r;
    endfunction

    task automatic issue_submit(mode_t m, logic [31:0] nsid, logic [63:0] slba,
                                logic [15:0] nlb, logic [63:0] prp);
        host_req_t r;
        r      = random_request(m);
        r.nsid = nsid;
        r.slba = slba;
        r.nlb  = nlb;
        r.prp  = prp;
        send_request(r);
    endtask

    task automatic issue_poll(logic [14:0] status, logic phase, logic [15:0] ccid);
        host_req_t r;
        r      = random_request(MODE_POLL);
        r.sw   = {status, phase};
        r.ccid = ccid;
        send_request(r);
    endtask

    // Field extremes, refusals on both sides, the flush layout and the
    // zero block count, all under the timeouts loaded by reset.
    task automatic test_directed_entries();
        issue_poll(15'h7FFF, 1'b1, FIRST_CMD_ID);
        issue_submit(MODE_READ, '1, '1, 16'h0000, '1);
        issue_submit(MODE_WRITE, '0, '0, 16'h0001, '0);
        issue_poll(15'h1234, ~exp_phase, pending_cid);
        issue_poll(15'h1234, exp_phase, pending_cid ^ 16'h8001);
        issue_poll(15'h7FFF, exp_phase, pending_cid);
        issue_submit(MODE_WRITE, '0, '0, 16'h0001, '0);
        issue_poll(15'h0000, exp_phase, pending_cid);
        issue_submit(MODE_FLUSH, '1, '1, 16'hFFFF, '1);
        issue_poll($urandom, exp_phase, pending_cid);
        issue_submit(MODE_WRITE, 32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF, 16'hFFFF,
                     64'hFEDC_BA98_7654_3210);
        issue_poll(15'h2AAA, ~exp_phase, ~pending_cid);
        issue_poll(15'h5555, exp_phase, pending_cid);
        drain_results(1000);
    endtask

    // Short timeouts for read/write and for flush, then the longest with a flush.
    task automatic test_timeouts();
        set_timeouts(23'd1, 23'd2);
        issue_submit(MODE_READ, $urandom, {$urandom, $urandom}, $urandom,
                     {$urandom, $urandom});
        issue_poll($urandom, exp_phase, pending_cid + 16'd1);
        issue_poll($urandom, exp_phase, pending_cid);
        issue_submit(MODE_FLUSH, $urandom, {$urandom, $urandom}, $urandom,
                     {$urandom, $urandom});
        issue_poll($urandom, ~exp_phase, pending_cid);
        issue_poll($urandom, ~exp_phase, pending_cid);
        issue_submit(MODE_WRITE, $urandom, {$urandom, $urandom}, $urandom,
                     {$urandom, $urandom});
        issue_poll($urandom, exp_phase, pending_cid);
        drain_results(1000);
        set_timeouts(TIMEOUT_MAX, TIMEOUT_MAX);
        issue_submit(MODE_FLUSH, $urandom, {$urandom, $urandom}, $urandom,
                     {$urandom, $urandom});
        issue_poll($urandom, ~exp_phase, pending_cid);
        issue_poll($urandom, exp_phase, ~pending_cid);
        issue_poll($urandom, exp_phase, pending_cid);
        drain_results(1000);
    endtask

    // The result side stalls for a long stretch while requests keep coming,
    // so the output register and the job queue fill and cmd.ready drops.
    // Afterwards the sender waits until every result is back.
    task automatic test_backpressure();
        idle_enable       = 1'b0;
        sink_hold_request = 60;
        repeat (6) begin
            issue_submit(mode_t'($urandom_range(0, 2)), $urandom, {$urandom, $urandom},
                         $urandom, {$urandom, $urandom});
            issue_poll($urandom, exp_phase, pending_cid);
        end
        drain_results(1000);
        idle_enable = 1'b1;
    endtask

    // Random requests. Most follow the protocol: submit when idle, then poll
    // with the right phase and id until done. The rest are wrong phases,
    // wrong ids, submissions that collide and polls with nothing pending.
    task automatic run_random_traffic(int count);
        host_req_t r;
        int        roll;
        repeat (count) begin
            r    = random_request(MODE_POLL);
            roll = $urandom_range(0, 99);
            if (!cmd_pending) begin
                if (roll < 88)
                    r.mode = mode_t'($urandom_range(0, 2));
            end
            else if (roll < 8) begin
                r.mode = mode_t'($urandom_range(0, 2));
            end
            else if (roll < 55) begin
                r.sw[0] = exp_phase;
                r.ccid  = pending_cid;
            end
            else if (roll < 70) begin
                r.sw[0] = ~exp_phase;
                r.ccid  = pending_cid;
            end
            else if (roll < 90) begin
                r.sw[0] = exp_phase;
                r.ccid  = pending_cid ^ 16'(1 << $urandom_range(0, 15));
            end
            case ($urandom_range(0, 9))
                0:       r.nlb = 16'h0000;
                1:       r.nlb = 16'hFFFF;
                default: ;
            endcase
            send_request(r);
        end
    endtask

    // Random traffic under several timeout settings, the extremes among
    // them. A zero register acts as one. The last phase runs without idling.
    task automatic test_random_traffic();
        idle_enable = 1'b1;
        set_timeouts(23'd3, 23'd2);
        run_random_traffic(180);
        drain_results(1000);
        set_timeouts(TIMEOUT_MAX, TIMEOUT_MAX);
        run_random_traffic(180);
        drain_results(1000);
        set_timeouts(23'd1, 23'd0);
        run_random_traffic(170);
        drain_results(1000);
        set_timeouts(23'd5, 23'd4);
        idle_enable = 1'b0;
        run_random_traffic(170);
    endtask

    initial begin
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        cmd_ch.valid           = 1'b0;
        cmd_ch.mode            = MODE_READ;
        cmd_ch.namespace_id    = '0;
        cmd_ch.start_block     = '0;
        cmd_ch.lba_count       = '0;
        cmd_ch.buffer_address  = '0;
        cmd_ch.cqe_status_word = '0;
        cmd_ch.cqe_command_id  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n       = 1'b1;
        idle_enable = 1'b1;

        test_directed_entries();
        test_timeouts();
        test_backpressure();
        test_random_traffic();

        // Let the last results come back, then keep running so that any stray
        // result from the pipeline shows.
        drain_results(1000);
        repeat (10) @(posedge clk);
        if (predicted_results.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_results.size());
            failures++;
        end

        $display("Run covered %0d requests: %0d submitted, %0d completed, %0d not yet,",
                 requests_sent, outcome_count[OC_SUBMITTED], outcome_count[OC_COMPLETED],
                 outcome_count[OC_NOT_YET]);
        $display("%0d timed out and %0d refused, under timeouts from zero to the maximum.",
                 outcome_count[OC_TIMEOUT], outcome_count[OC_REFUSED]);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
